[rtl/bms_pkg.sv]
// bitmap sorter package: sizes, state and command types
package bms_pkg;

   localparam int VALUE_BITS = 16;
   localparam int WORD_BITS  = 32;
   localparam int IN_BITS    = 16;
   localparam int OUT_BITS   = 16;
   localparam int BIT_BITS   = $clog2(WORD_BITS);
   localparam int NUM_WORDS  = ((2 ** VALUE_BITS) + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_BITS  = $clog2(NUM_WORDS);
   localparam int PTR_BITS   = VALUE_BITS + 1;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [WIDX_BITS-1:0] widx_type;
   typedef logic [BIT_BITS-1:0]  bidx_type;
   typedef logic [PTR_BITS-1:0]  ptr_type;

   typedef enum logic [0:0] {
      KIND_INSERT = 1'b0,
      KIND_NEXT   = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_WR,
      ST_SCAN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic ins_write;
      logic scan_hit;
      logic scan_next;
      logic scan_miss;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic ptr_empty;
      logic hit;
      logic last_word;
      logic out_free;
   } status_type;

endpackage

[rtl/bms_req_if.sv]
// request channel: operation kind and value with valid/ready handshake
interface bms_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [bms_pkg::IN_BITS-1:0]  value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

[rtl/bms_rsp_if.sv]
// response channel: sorted value and found flag with valid/ready handshake
interface bms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bms_pkg::OUT_BITS-1:0]  sorted_value;
   logic                          found;

   modport source (output valid, output sorted_value, output found, input ready);
   modport sink   (input valid, input sorted_value, input found, output ready);
endinterface

[rtl/bms_ctrl.sv]
// bitmap sorter controller: state machine sequencing clear, insert and scan
module bms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_ready,
   input  bms_pkg::status_type status,
   output bms_pkg::cmd_type    cmd
);

   bms_pkg::state_type state_ff;
   bms_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bms_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         bms_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clr_last) begin
               state_in = bms_pkg::ST_IDLE;
            end
         end
         bms_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_kind == bms_pkg::KIND_INSERT) begin
                  state_in = bms_pkg::ST_INS_WR;
               end else if (status.ptr_empty) begin
                  cmd.scan_miss = 1'b1;
                  state_in      = bms_pkg::ST_RESULT;
               end else begin
                  state_in = bms_pkg::ST_SCAN;
               end
            end
         end
         bms_pkg::ST_INS_WR: begin
            cmd.ins_write = 1'b1;
            state_in      = bms_pkg::ST_IDLE;
         end
         bms_pkg::ST_SCAN: begin
            if (status.hit) begin
               cmd.scan_hit = 1'b1;
               state_in     = bms_pkg::ST_RESULT;
            end else if (status.last_word) begin
               cmd.scan_miss = 1'b1;
               state_in      = bms_pkg::ST_RESULT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         bms_pkg::ST_RESULT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = bms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bms_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

[rtl/bms_dpath.sv]
// bitmap sorter datapath: bitmap memory, scan pointer, bit search and output register
module bms_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_kind,
   input  logic [bms_pkg::IN_BITS-1:0]   req_value,
   input  bms_pkg::cmd_type              cmd,
   output bms_pkg::status_type           status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bms_pkg::OUT_BITS-1:0]  rsp_sorted_value,
   output logic                          rsp_found
);

   localparam bms_pkg::ptr_type  RangePtr = bms_pkg::ptr_type'(2 ** bms_pkg::VALUE_BITS);
   localparam bms_pkg::widx_type LastWord = bms_pkg::widx_type'(bms_pkg::NUM_WORDS - 1);

   bms_pkg::word_type mem [bms_pkg::NUM_WORDS];

   bms_pkg::widx_type clr_addr_ff, clr_addr_in;
   bms_pkg::ptr_type  ptr_ff, ptr_in;
   bms_pkg::widx_type word_ff, word_in;
   bms_pkg::bidx_type bit_ff, bit_in;
   bms_pkg::word_type rd_data_ff;
   logic [bms_pkg::OUT_BITS-1:0] res_value_ff, res_value_in;
   logic                         res_found_ff, res_found_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bms_pkg::OUT_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_found_ff, rsp_found_in;

   logic [bms_pkg::VALUE_BITS-1:0] req_val;
   logic [bms_pkg::VALUE_BITS-1:0] ins_val;
   logic [bms_pkg::VALUE_BITS-1:0] hit_val;
   bms_pkg::word_type              masked;
   bms_pkg::bidx_type              low_idx;
   logic                           rd_en;
   bms_pkg::widx_type              rd_addr;
   logic                           wr_en;
   bms_pkg::widx_type              wr_addr;
   bms_pkg::word_type              wr_data;

   assign req_val = bms_pkg::VALUE_BITS'(req_value);
   assign ins_val = {word_ff, bit_ff};
   assign masked  = rd_data_ff & ({bms_pkg::WORD_BITS{1'b1}} << bit_ff);

   always_comb begin
      low_idx = '0;
      for (int i = bms_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (masked[i]) begin
            low_idx = bms_pkg::bidx_type'(i);
         end
      end
   end

   assign hit_val = {word_ff, low_idx};

   assign status.clr_last  = (clr_addr_ff == LastWord);
   assign status.ptr_empty = ptr_ff[bms_pkg::VALUE_BITS];
   assign status.hit       = |masked;
   assign status.last_word = (word_ff == LastWord);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = word_ff;
      wr_en   = 1'b0;
      wr_addr = word_ff;
      wr_data = rd_data_ff;
      if (cmd.accept) begin
         rd_en   = 1'b1;
         rd_addr = (req_kind == bms_pkg::KIND_INSERT)
                   ? req_val[bms_pkg::VALUE_BITS-1:bms_pkg::BIT_BITS]
                   : ptr_ff[bms_pkg::VALUE_BITS-1:bms_pkg::BIT_BITS];
      end else if (cmd.scan_next) begin
         rd_en   = 1'b1;
         rd_addr = word_ff + 1'b1;
      end
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (cmd.ins_write) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff | (bms_pkg::word_type'(1) << bit_ff);
      end else if (cmd.scan_hit) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff & ~(bms_pkg::word_type'(1) << low_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // pointer, scan position and result
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      ptr_in       = ptr_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      res_value_in = res_value_ff;
      res_found_in = res_found_ff;
      if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + 1'b1;
      end
      if (cmd.accept) begin
         if (req_kind == bms_pkg::KIND_INSERT) begin
            word_in = req_val[bms_pkg::VALUE_BITS-1:bms_pkg::BIT_BITS];
            bit_in  = req_val[bms_pkg::BIT_BITS-1:0];
         end else begin
            word_in = ptr_ff[bms_pkg::VALUE_BITS-1:bms_pkg::BIT_BITS];
            bit_in  = ptr_ff[bms_pkg::BIT_BITS-1:0];
         end
      end
      if (cmd.ins_write && (bms_pkg::ptr_type'(ins_val) < ptr_ff)) begin
         ptr_in = bms_pkg::ptr_type'(ins_val);
      end
      if (cmd.scan_next) begin
         word_in = word_ff + 1'b1;
         bit_in  = '0;
      end
      if (cmd.scan_hit) begin
         ptr_in       = bms_pkg::ptr_type'(hit_val) + 1'b1;
         res_value_in = bms_pkg::OUT_BITS'(hit_val);
         res_found_in = 1'b1;
      end
      if (cmd.scan_miss) begin
         ptr_in       = RangePtr;
         res_value_in = '0;
         res_found_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_value_ff;
         rsp_found_in = res_found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         ptr_ff       <= RangePtr;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      bit_ff       <= bit_in;
      res_value_ff <= res_value_in;
      res_found_ff <= res_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_found        = rsp_found_ff;

endmodule

[rtl/bitmap_sorter.sv]
// bitmap sorter top level: request and response channels around controller and datapath
// Values are kept as one presence bit each in a 2048 x 32 single-port-read memory. After reset
// a clearing pass zeroes the memory, one word per cycle, before the first request beat is
// taken. An insert beat does a word read, then a read-modify-write. A next beat reads
// memory words, one word read per cycle, from the scan pointer up to the word holding the
// lowest set bit, or up to the last word if none is found (1 to 2048 words); when nothing
// is pending it skips the scan. The result waits in an output register, and
// a following next beat stalls only if that register is still full when its result is ready.
module bitmap_sorter (
   input  logic            clock,
   input  logic            reset,
   bms_req_if.sink         req,
   bms_rsp_if.source       rsp
);

   bms_pkg::cmd_type    cmd;
   bms_pkg::status_type status;

   bms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_kind  (req.kind),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bms_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req.kind),
      .req_value        (req.value),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_sorted_value (rsp.sorted_value),
      .rsp_found        (rsp.found)
   );

endmodule
